>>> hdl/deficit_round_robin_scheduler_macros.svh
// Assertion macros used by the scheduler checker
`ifndef DEFICIT_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define DEFICIT_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define DRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define DRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/drr_pkg.sv
// Types and constants shared by the deficit round robin scheduler
package drr_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CLASS_W     = 2;
  localparam int WORD_W      = 16;
  localparam int DEFICIT_W   = 18;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CLASS_W-1:0]   LAST_CLASS  = CLASS_W'(NUM_CLASSES - 1);
  localparam logic [DEFICIT_W-1:0] DEFICIT_MAX = '1;

  typedef logic [NUM_CLASSES-1:0][WORD_W-1:0] word_array_t;

  localparam word_array_t PORT_RST    = {16'd65533, 16'd65534, 16'd65535};
  localparam word_array_t QUANTUM_RST = {16'd100, 16'd200, 16'd300};

  typedef enum logic {
    ACT_ENQUEUE  = 1'b0,
    ACT_SCHEDULE = 1'b1
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PORT0    = 3'd0,
    REG_PORT1    = 3'd1,
    REG_PORT2    = 3'd2,
    REG_QUANTUM0 = 3'd3,
    REG_QUANTUM1 = 3'd4,
    REG_QUANTUM2 = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_HEAD,
    BS_NEXT,
    BS_EMIT
  } back_state_t;

  // Classified request passed from front to back
  typedef struct packed {
    action_t             action;
    logic [CLASS_W-1:0]  cls;
    logic [WORD_W-1:0]   length;
    logic [WORD_W-1:0]   tag;
  } cmd_t;

  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic                dropped;
    logic                served;
    logic [WORD_W-1:0]   tag;
    logic [WORD_W-1:0]   length;
  } res_t;

endpackage

>>> hdl/drr_ram.sv
// Generic single-write, single-read RAM with registered read data
module drr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/drr_front.sv
// Front end: accept requests, classify by source port, hold them in a short queue
module drr_front import drr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  word_array_t           port_class,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] n_r, n_nxt;
  logic       push;
  cmd_t       new_cmd;
  logic [CLASS_W-1:0] cls;

  // Lowest matching class wins; no match goes to the last class
  always_comb begin
    cls = LAST_CLASS;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (port_class[c] == in_tdata[15:0]) begin
        cls = CLASS_W'(c);
      end
    end
    new_cmd.action = action_t'(in_tuser);
    new_cmd.cls    = cls;
    new_cmd.length = in_tdata[31:16];
    new_cmd.tag    = in_tdata[47:32];
  end

  assign in_tready = (n_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (n_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    n_nxt = n_r;
    if (push && !cmd_pop) begin
      n_nxt = n_r + 2'd1;
    end else if (!push && cmd_pop) begin
      n_nxt = n_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      n_r <= n_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (cmd_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= new_cmd;
    end
  end

endmodule

>>> hdl/drr_back.sv
// Back end: per-class queues, deficit accounting and the result register
module drr_back import drr_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  word_array_t quantum,
  output logic        out_valid,
  output res_t        out_res,
  input  logic        out_ready
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = PW + 1;
  localparam int AW = $clog2(NUM_CLASSES * QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_SUM = SW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] HEAD_LAST = PW'(QUEUE_DEPTH - 1);

  back_state_t        st_r, st_nxt;
  logic [PW-1:0]      head_r  [NUM_CLASSES];
  logic [PW-1:0]      head_nxt[NUM_CLASSES];
  logic [CW-1:0]      count_r  [NUM_CLASSES];
  logic [CW-1:0]      count_nxt[NUM_CLASSES];
  logic [DEFICIT_W-1:0] def_r  [NUM_CLASSES];
  logic [DEFICIT_W-1:0] def_nxt[NUM_CLASSES];
  logic [CLASS_W-1:0] cur_r, cur_nxt, adv_cls;
  logic               refresh_r, refresh_nxt;
  res_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r;
  logic               out_load;
  logic               any_queued;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_rdata;
  logic [WORD_W-1:0]  rd_len;
  logic [SW-1:0]      tail_sum, tail_off;
  logic [DEFICIT_W:0] credit;
  logic [DEFICIT_W-1:0] cur_def;

  function automatic logic [AW-1:0] slot_addr(input logic [CLASS_W-1:0] c,
                                               input logic [PW-1:0] off);
    slot_addr = AW'(c) * AW'(QUEUE_DEPTH) + AW'(off);
  endfunction

  function automatic logic [PW-1:0] head_inc(input logic [PW-1:0] h);
    head_inc = (h == HEAD_LAST) ? '0 : h + PW'(1);
  endfunction

  drr_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (NUM_CLASSES * QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cmd.tag, cmd.length}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_len    = ram_rdata[15:0];
  assign adv_cls   = (cur_r == LAST_CLASS) ? '0 : cur_r + CLASS_W'(1);
  assign cur_def   = def_r[cur_r];
  assign tail_sum  = SW'(head_r[cmd.cls]) + SW'(count_r[cmd.cls]);
  assign tail_off  = (tail_sum >= DEPTH_SUM) ? tail_sum - DEPTH_SUM : tail_sum;
  assign ram_waddr = slot_addr(cmd.cls, tail_off[PW-1:0]);

  always_comb begin
    any_queued = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      any_queued = any_queued || (count_r[c] != '0);
    end
  end

  always_comb begin
    st_nxt      = st_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    def_nxt     = def_r;
    cur_nxt     = cur_r;
    refresh_nxt = refresh_r;
    res_nxt     = res_r;
    cmd_pop     = 1'b0;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = slot_addr(cur_r, head_r[cur_r]);
    credit      = '0;

    case (st_r)
      BS_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          res_nxt = '0;
          st_nxt  = BS_EMIT;
          if (cmd.action == ACT_ENQUEUE) begin
            res_nxt.cls = cmd.cls;
            if (count_r[cmd.cls] == DEPTH_CNT) begin
              res_nxt.dropped = 1'b1;
            end else begin
              ram_we = 1'b1;
              count_nxt[cmd.cls] = count_r[cmd.cls] + CW'(1);
            end
          end else begin
            res_nxt.cls = cur_r;
            if (any_queued) begin
              if (refresh_r) begin
                for (int c = 0; c < NUM_CLASSES; c++) begin
                  credit = {1'b0, def_r[c]} + (DEFICIT_W + 1)'(quantum[c]);
                  def_nxt[c] = credit[DEFICIT_W] ? DEFICIT_MAX : credit[DEFICIT_W-1:0];
                end
                refresh_nxt = 1'b0;
              end
              if (count_r[cur_r] == '0) begin
                // Empty class: drop its credit and move on
                def_nxt[cur_r] = '0;
                cur_nxt = adv_cls;
                if (adv_cls == '0) begin
                  refresh_nxt = 1'b1;
                end
              end else begin
                st_nxt = BS_HEAD;
              end
            end
          end
        end
      end

      BS_HEAD: begin
        st_nxt = BS_EMIT;
        if (DEFICIT_W'(rd_len) <= cur_def) begin
          res_nxt.served = 1'b1;
          res_nxt.tag    = ram_rdata[31:16];
          res_nxt.length = rd_len;
          def_nxt[cur_r]   = cur_def - DEFICIT_W'(rd_len);
          head_nxt[cur_r]  = head_inc(head_r[cur_r]);
          count_nxt[cur_r] = count_r[cur_r] - CW'(1);
          if (count_r[cur_r] == CW'(1)) begin
            def_nxt[cur_r] = '0;
            cur_nxt = adv_cls;
            if (adv_cls == '0) begin
              refresh_nxt = 1'b1;
            end
          end else begin
            // Fetch the new head to decide whether to stay on this class
            ram_raddr = slot_addr(cur_r, head_inc(head_r[cur_r]));
            st_nxt = BS_NEXT;
          end
        end else begin
          cur_nxt = adv_cls;
          if (adv_cls == '0) begin
            refresh_nxt = 1'b1;
          end
        end
      end

      BS_NEXT: begin
        st_nxt = BS_EMIT;
        if (DEFICIT_W'(rd_len) > cur_def) begin
          cur_nxt = adv_cls;
          if (adv_cls == '0) begin
            refresh_nxt = 1'b1;
          end
        end
      end

      BS_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          st_nxt   = BS_IDLE;
        end
      end

      default: begin
        st_nxt = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BS_IDLE;
      cur_r       <= '0;
      refresh_r   <= 1'b1;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c]  <= '0;
        count_r[c] <= '0;
        def_r[c]   <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      cur_r       <= cur_nxt;
      refresh_r   <= refresh_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      def_r       <= def_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> hdl/deficit_round_robin_scheduler.sv
// Three-class deficit round robin packet scheduler, top level
//
//   channel  dir  handshake                contents
//   in_      in   in_tvalid / in_tready    tuser action; tdata port, length, tag
//   out_     out  out_tvalid / out_tready  tdata class, dropped, served, tag, length
//   cfg_     in   cfg_wr_en                cfg_addr register, cfg_wdata value
//
// One request is carried out at a time by the back end. An enqueue goes straight to
// emit; a schedule may first make up to two dependent reads of the packet RAM (head,
// then new head) with registered read data. A two-entry request queue accepts new
// requests while the back end works; the result register frees the back end while
// a result waits. Reset is synchronous; the packet RAM needs no clearing.
module deficit_round_robin_scheduler import drr_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // source_port, packet_length, packet_tag
  input  logic                   in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // class_index, dropped, served, out_tag,
                                             // out_length, zero fill
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [WORD_W-1:0]      cfg_wdata
);

  word_array_t port_r, quantum_r;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;
  res_t        out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r    <= PORT_RST;
      quantum_r <= QUANTUM_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PORT0:    port_r[0]    <= cfg_wdata;
        REG_PORT1:    port_r[1]    <= cfg_wdata;
        REG_PORT2:    port_r[2]    <= cfg_wdata;
        REG_QUANTUM0: quantum_r[0] <= cfg_wdata;
        REG_QUANTUM1: quantum_r[1] <= cfg_wdata;
        REG_QUANTUM2: quantum_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  drr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .port_class (port_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  drr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .quantum   (quantum_r),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = {4'd0, out_res.length, out_res.tag, out_res.served,
                      out_res.dropped, out_res.cls};

endmodule

>>> hdl/drr_checker.sv
// Port-level checks on the scheduler result channel, bound to the top level
`include "deficit_round_robin_scheduler_macros.svh"

module drr_checker import drr_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `DRR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `DRR_ASSERT_NOW(a_one_flag, clk, rst_n, out_tvalid, !(out_tdata[2] && out_tdata[3]), "dropped and served together")
  `DRR_ASSERT_NOW(a_class_range, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'd3, "class index out of range")
  `DRR_ASSERT_NOW(a_idle_payload, clk, rst_n, out_tvalid && !out_tdata[3], out_tdata[35:4] == 32'd0, "tag or length without service")

endmodule

bind deficit_round_robin_scheduler drr_checker u_drr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
